// File: hw/rtl/skt_pkg.sv
package skt_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key;
    logic [7:0]         age_in;
    logic [31:0]        salary_in;
    logic [3:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key_out;
    logic [7:0]         age_out;
    logic [31:0]        salary_out;
    logic [4:0]         entry_count;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         age;
    logic [31:0]        salary;
  } record_t;

  localparam int RecW = $bits(record_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_WALK,
    S_INS_PLACE,
    S_SCAN,
    S_DEL_WALK,
    S_RD_DATA,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_TOP,
    IDX_INC,
    IDX_DEC,
    IDX_POS
  } idx_op_e;

  typedef enum logic [1:0] {
    WA_UP,
    WA_DOWN,
    WA_ZERO
  } wa_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic    load_item;
    idx_op_e idx_op;
    logic    wr_en;
    wa_sel_e wr_addr_sel;
    logic    wr_from_item;
    cnt_op_e cnt_op;
    logic    res_load;
    status_e res_status;
    logic    res_take_rec;
    logic    out_push;
  } ctrl_t;

  typedef struct packed {
    action_e action;
    logic    count_zero;
    logic    full;
    logic    pos_oob;
    logic    key_lt;
    logic    key_eq;
    logic    idx_zero;
    logic    idx_last;
    logic    out_free;
  } stat_t;

endpackage

// File: hw/rtl/skt_ram.sv
module skt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/skt_ctrl.sv
module skt_ctrl import skt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d             = state_q;
    in_ready_o          = 1'b0;
    ctrl_o              = '0;
    ctrl_o.idx_op       = IDX_HOLD;
    ctrl_o.wr_addr_sel  = WA_UP;
    ctrl_o.cnt_op       = CNT_HOLD;
    ctrl_o.res_status   = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load_item = 1'b1;
          state_d          = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.action) inside
          ACT_INSERT: begin
            if (stat_i.full) begin
              ctrl_o.res_load   = 1'b1;
              ctrl_o.res_status = ST_FULL;
              state_d           = S_RESP;
            end else if (stat_i.count_zero) begin
              ctrl_o.wr_en        = 1'b1;
              ctrl_o.wr_addr_sel  = WA_ZERO;
              ctrl_o.wr_from_item = 1'b1;
              ctrl_o.cnt_op       = CNT_INC;
              ctrl_o.res_load     = 1'b1;
              state_d             = S_RESP;
            end else begin
              ctrl_o.idx_op = IDX_TOP;
              state_d       = S_INS_WALK;
            end
          end
          ACT_DELETE, ACT_SEARCH: begin
            if (stat_i.count_zero) begin
              ctrl_o.res_load   = 1'b1;
              ctrl_o.res_status = ST_NOT_FOUND;
              state_d           = S_RESP;
            end else begin
              ctrl_o.idx_op = IDX_ZERO;
              state_d       = S_SCAN;
            end
          end
          default: begin
            if (stat_i.pos_oob) begin
              ctrl_o.res_load   = 1'b1;
              ctrl_o.res_status = ST_RANGE;
              state_d           = S_RESP;
            end else begin
              ctrl_o.idx_op = IDX_POS;
              state_d       = S_RD_DATA;
            end
          end
        endcase
      end
      S_INS_WALK: begin
        ctrl_o.wr_en       = 1'b1;
        ctrl_o.wr_addr_sel = WA_UP;
        if (stat_i.key_lt) begin
          ctrl_o.wr_from_item = 1'b1;
          ctrl_o.cnt_op       = CNT_INC;
          ctrl_o.res_load     = 1'b1;
          state_d             = S_RESP;
        end else if (stat_i.idx_zero) begin
          state_d = S_INS_PLACE;
        end else begin
          ctrl_o.idx_op = IDX_DEC;
        end
      end
      S_INS_PLACE: begin
        ctrl_o.wr_en        = 1'b1;
        ctrl_o.wr_addr_sel  = WA_ZERO;
        ctrl_o.wr_from_item = 1'b1;
        ctrl_o.cnt_op       = CNT_INC;
        ctrl_o.res_load     = 1'b1;
        state_d             = S_RESP;
      end
      S_SCAN: begin
        if (stat_i.key_lt) begin
          if (stat_i.idx_last) begin
            ctrl_o.res_load   = 1'b1;
            ctrl_o.res_status = ST_NOT_FOUND;
            state_d           = S_RESP;
          end else begin
            ctrl_o.idx_op = IDX_INC;
          end
        end else if (stat_i.key_eq) begin
          if (stat_i.action == ACT_SEARCH) begin
            ctrl_o.res_load     = 1'b1;
            ctrl_o.res_take_rec = 1'b1;
            state_d             = S_RESP;
          end else if (stat_i.idx_last) begin
            ctrl_o.cnt_op   = CNT_DEC;
            ctrl_o.res_load = 1'b1;
            state_d         = S_RESP;
          end else begin
            ctrl_o.idx_op = IDX_INC;
            state_d       = S_DEL_WALK;
          end
        end else begin
          ctrl_o.res_load   = 1'b1;
          ctrl_o.res_status = ST_NOT_FOUND;
          state_d           = S_RESP;
        end
      end
      S_DEL_WALK: begin
        ctrl_o.wr_en       = 1'b1;
        ctrl_o.wr_addr_sel = WA_DOWN;
        if (stat_i.idx_last) begin
          ctrl_o.cnt_op   = CNT_DEC;
          ctrl_o.res_load = 1'b1;
          state_d         = S_RESP;
        end else begin
          ctrl_o.idx_op = IDX_INC;
        end
      end
      S_RD_DATA: begin
        ctrl_o.res_load     = 1'b1;
        ctrl_o.res_take_rec = 1'b1;
        state_d             = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          ctrl_o.out_push = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/skt_datapath.sv
module skt_datapath import skt_pkg::*; #(
  parameter int Depth = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  ctrl_t     ctrl_i,
  output stat_t     stat_o
);

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);
  localparam int XW = (CW > 4) ? CW : 4;

  in_item_t       item_q;
  logic [AW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  count_m1;
  logic [AW-1:0]  wr_addr;
  record_t        wr_rec, ram_rec, item_rec;
  logic [1:0]     res_status_q;
  record_t        res_rec_q;
  logic           out_valid_q;
  out_item_t      out_q;

  assign item_rec = '{key: item_q.key, age: item_q.age_in, salary: item_q.salary_in};
  assign count_m1 = count_q - CW'(1);

  always_comb begin
    case (ctrl_i.idx_op)
      IDX_ZERO: idx_d = '0;
      IDX_TOP:  idx_d = count_m1[AW-1:0];
      IDX_INC:  idx_d = idx_q + AW'(1);
      IDX_DEC:  idx_d = idx_q - AW'(1);
      IDX_POS:  idx_d = AW'(item_q.position);
      default:  idx_d = idx_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.wr_addr_sel)
      WA_UP:   wr_addr = idx_q + AW'(1);
      WA_DOWN: wr_addr = idx_q - AW'(1);
      default: wr_addr = '0;
    endcase
  end

  assign wr_rec = ctrl_i.wr_from_item ? item_rec : ram_rec;

  always_comb begin
    case (ctrl_i.cnt_op)
      CNT_INC: count_d = count_q + CW'(1);
      CNT_DEC: count_d = count_m1;
      default: count_d = count_q;
    endcase
  end

  skt_ram #(
    .Width (RecW),
    .Depth (Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ctrl_i.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_rec),
    .rd_addr_i (idx_d),
    .rd_data_o (ram_rec)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      item_q <= in_item_i;
    end
    idx_q <= idx_d;
    if (ctrl_i.res_load) begin
      res_status_q <= ctrl_i.res_status;
      res_rec_q    <= ctrl_i.res_take_rec ? ram_rec : '0;
    end
    if (ctrl_i.out_push) begin
      out_q.status      <= res_status_q;
      out_q.key_out     <= res_rec_q.key;
      out_q.age_out     <= res_rec_q.age;
      out_q.salary_out  <= res_rec_q.salary;
      out_q.entry_count <= 5'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (ctrl_i.out_push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign stat_o.action     = action_e'(item_q.action);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.full       = (count_q == CW'(Depth));
  assign stat_o.pos_oob    = (XW'(item_q.position) >= XW'(count_q));
  assign stat_o.key_lt     = ($signed(ram_rec.key) < $signed(item_q.key));
  assign stat_o.key_eq     = (ram_rec.key == item_q.key);
  assign stat_o.idx_zero   = (idx_q == '0);
  assign stat_o.idx_last   = ((CW'(idx_q) + CW'(1)) == count_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == CW'($past(count_q) + CW'(1)) || CW'(count_q + CW'(1)) == $past(count_q)))
    else $error("entry count moved by more than one");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.wr_en |-> (CW'(wr_addr) <= count_q) && (count_q != CW'(Depth)
                      || ctrl_i.wr_addr_sel == WA_DOWN))
    else $error("table write beyond stored entries");

endmodule

// File: hw/rtl/sorted_key_record_table_unit.sv
// Sorted record table: up to DEPTH records (signed key, age, salary in cents) kept in
// ascending key order in one single-port-write RAM with registered read. One item is
// worked at a time and each gives exactly one result carrying the entry count. Run time
// is set by the sequential walk over the RAM, one entry per cycle: insert shifts entries
// up from the top down to the insertion point, delete scans up to the match and shifts
// the later entries down, search scans from the lowest key up to the match, and read by
// position and full, empty or out-of-range cases need no walk; all wait on output stalls.
// A result waits in an output register while the next item is accepted.
module sorted_key_record_table_unit import skt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  ctrl_t ctrl;
  stat_t stat;

  skt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  skt_datapath #(
    .Depth (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

// File: test/sorted_key_record_table_unit_tb.sv
module sorted_key_record_table_unit_tb;
  import skt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = 16;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  sorted_key_record_table_unit #(
    .DEPTH(TableDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  class table_scoreboard;
    record_t   table_recs[TableDepth];
    int        fill;
    out_item_t pending_results[$];
    int        mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    // first entry whose key is not below k, fill if none
    function int first_not_less(logic signed [31:0] k);
      int i;
      i = 0;
      while (i < fill && $signed(table_recs[i].key) < k) i++;
      return i;
    endfunction

    function out_item_t predict_result(in_item_t it);
      out_item_t r;
      int        idx;
      int        j;
      r = '0;
      case (it.action) inside
        ACT_INSERT: begin
          if (fill >= TableDepth) begin
            r.status = ST_FULL;
          end else begin
            idx = first_not_less(it.key);
            for (j = fill; j > idx; j--) table_recs[j] = table_recs[j-1];
            table_recs[idx] = '{key: it.key, age: it.age_in, salary: it.salary_in};
            fill++;
            r.status = ST_OK;
          end
        end
        ACT_DELETE, ACT_SEARCH: begin
          idx = first_not_less(it.key);
          if (idx >= fill || table_recs[idx].key != it.key) begin
            r.status = ST_NOT_FOUND;
          end else if (it.action == ACT_SEARCH) begin
            r.status     = ST_OK;
            r.key_out    = table_recs[idx].key;
            r.age_out    = table_recs[idx].age;
            r.salary_out = table_recs[idx].salary;
          end else begin
            for (j = idx; j < fill - 1; j++) table_recs[j] = table_recs[j+1];
            fill--;
            r.status = ST_OK;
          end
        end
        default: begin
          if (int'(it.position) >= fill) begin
            r.status = ST_RANGE;
          end else begin
            r.status     = ST_OK;
            r.key_out    = table_recs[it.position].key;
            r.age_out    = table_recs[it.position].age;
            r.salary_out = table_recs[it.position].salary;
          end
        end
      endcase
      r.entry_count = 5'(fill);
      return r;
    endfunction

    function void note_item(in_item_t it);
      pending_results.push_back(predict_result(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      bit        bad;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = pending_results.pop_front();
      bad = (got.status !== want.status) || (got.key_out !== want.key_out) ||
            (got.age_out !== want.age_out) || (got.salary_out !== want.salary_out) ||
            (got.entry_count !== want.entry_count);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch at %0t: exp st %0d key %0d age %0d sal %0h cnt %0d, ",
                    "got st %0d key %0d age %0d sal %0h cnt %0d"},
                   $time, want.status, want.key_out, want.age_out, want.salary_out,
                   want.entry_count, got.status, got.key_out, got.age_out, got.salary_out,
                   got.entry_count);
      end
    endfunction
  endclass

  table_scoreboard sb = new();

  logic signed [31:0] key_pool[8];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("sorted_key_record_table_unit_tb: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // receiver: stretches of always-ready, coin-flip and long stalls
  initial begin
    int rx_mode;
    int mode_left;
    int hold_left;
    bit hold_ready;
    mode_left = 0;
    hold_left = 0;
    hold_ready = 1'b0;
    rx_mode = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: begin
          if (hold_left == 0) begin
            hold_ready = !hold_ready;
            hold_left  = hold_ready ? $urandom_range(1, 3) : $urandom_range(1, 16);
          end
          hold_left--;
          out_ready_i <= hold_ready;
        end
      endcase
    end
  end

  task automatic push_item(in_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
  endtask

  task automatic idle_sender(int cycles);
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    in_item_i  <= noise[$bits(in_item_t)-1:0];
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_drained(int max_cycles);
    int n;
    n = 0;
    while (sb.pending_results.size() != 0 && n < max_cycles) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  function automatic in_item_t make_item(action_e act, logic signed [31:0] k, logic [7:0] age,
                                         logic [31:0] sal, logic [3:0] pos);
    in_item_t it;
    it = '{action: act, key: k, age_in: age, salary_in: sal, position: pos};
    return it;
  endfunction

  function automatic in_item_t random_item(int ins_weight);
    in_item_t it;
    int       r;
    int       rest;
    r    = $urandom_range(0, 99);
    rest = 100 - ins_weight;
    if (r < ins_weight) it.action = ACT_INSERT;
    else if (r < ins_weight + rest / 3) it.action = ACT_DELETE;
    else if (r < ins_weight + 2 * rest / 3) it.action = ACT_SEARCH;
    else it.action = ACT_READ;
    it.key       = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
    it.age_in    = 8'($urandom);
    it.salary_in = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
    it.position  = 4'($urandom);
    return it;
  endfunction

  initial begin
    int phase;
    int n;
    int ins_weight;
    int burst_left;
    bit gappy;
    int failures;

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (n = 4; n < 8; n++) key_pool[n] = $urandom;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, extremes, duplicate keys
    push_item(make_item(ACT_READ,   0, 8'd0, 32'd0, 4'd0));
    push_item(make_item(ACT_SEARCH, 0, 8'd0, 32'd0, 4'd0));
    push_item(make_item(ACT_DELETE, 0, 8'd0, 32'd0, 4'd0));
    push_item(make_item(ACT_INSERT, 32'sh7FFF_FFFF, 8'd255, 32'hFFFF_FFFF, 4'd0));
    push_item(make_item(ACT_INSERT, 32'sh8000_0000, 8'd0, 32'd0, 4'd15));
    push_item(make_item(ACT_INSERT, 0, 8'd1, 32'd100, 4'd0));
    push_item(make_item(ACT_INSERT, 0, 8'd2, 32'd200, 4'd0));
    push_item(make_item(ACT_INSERT, -1, 8'hAA, 32'h5555_AAAA, 4'd0));
    push_item(make_item(ACT_SEARCH, 0, 8'd0, 32'd0, 4'd0));
    push_item(make_item(ACT_SEARCH, 32'sh8000_0000, 8'd0, 32'd0, 4'd0));
    push_item(make_item(ACT_READ,   0, 8'd0, 32'd0, 4'd0));
    push_item(make_item(ACT_READ,   0, 8'd0, 32'd0, 4'd4));
    push_item(make_item(ACT_READ,   0, 8'd0, 32'd0, 4'd5));
    push_item(make_item(ACT_READ,   0, 8'd0, 32'd0, 4'd15));
    push_item(make_item(ACT_DELETE, 0, 8'd0, 32'd0, 4'd0));
    push_item(make_item(ACT_SEARCH, 0, 8'd0, 32'd0, 4'd0));
    push_item(make_item(ACT_DELETE, 32'sd12345, 8'd0, 32'd0, 4'd0));
    push_item(make_item(ACT_DELETE, 32'sh7FFF_FFFF, 8'd0, 32'd0, 4'd0));

    // hold off until the table has answered everything
    idle_sender(1);
    wait_drained(20000);

    burst_left = 0;
    for (phase = 0; phase < 18; phase++) begin
      if (phase == 0) ins_weight = 85;
      else if (phase == 1) ins_weight = 15;
      else ins_weight = $urandom_range(10, 90);
      gappy = ($urandom_range(0, 3) != 0);
      for (n = 0; n < 102; n++) begin
        if (gappy && burst_left == 0) begin
          idle_sender($urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 5));
          burst_left = $urandom_range(1, 12);
        end
        push_item(random_item(ins_weight));
        if (burst_left > 0) burst_left--;
      end
      if (phase == 8) begin
        idle_sender(1);
        wait_drained(20000);
      end
    end

    idle_sender(1);
    wait_drained(20000);
    repeat (40) @(posedge clk_i);

    failures = sb.mismatches + sb.pending_results.size();
    if (failures == 0) $display("sorted_key_record_table_unit_tb: done, clean");
    else $display("sorted_key_record_table_unit_tb: done, errors");
    $finish;
  end

endmodule
